### hdl/mmpc_pkg.sv
// ----------------------------------------------------------------------------
// mmpc_pkg: shared types and constants
// Types, codes and helper functions used by the motor PWM command controller.
// ----------------------------------------------------------------------------
package mmpc_pkg;

    // sizes
    localparam int MOTOR_COUNT = 8;
    localparam int ZONE_COUNT  = 4;
    localparam int DUTY_LANES  = 8;
    localparam int PHASE_W     = 2;

    // level and duty constants
    localparam int LEVEL_MAX          = 100;
    localparam int DUTY_FULL          = 255;
    localparam int WAVE_LEVEL_DEFAULT = 60;
    localparam int MS_PER_MIN         = 60000;

    // x / 99 as (x * RECIP_99) >> RECIP_SHIFT, exact for x below 2**15
    localparam int RECIP_99    = 21184;
    localparam int RECIP_SHIFT = 21;

    // register reset values
    localparam logic [7:0]  RST_OWN_BED_ID       = 8'd1;
    localparam logic [7:0]  RST_DUTY_FLOOR_SMALL = 8'd60;
    localparam logic [7:0]  RST_DUTY_FLOOR_BIG   = 8'd165;
    localparam logic [7:0]  RST_BIG_MOTOR_MASK   = 8'd61;
    localparam logic [15:0] RST_ZONE_MAP         = 16'd64080;
    localparam logic [7:0]  RST_KICK_MS          = 8'd60;
    localparam logic [15:0] RST_WAVE_STEP_MS     = 16'd1500;

    typedef logic [6:0] level_t;
    typedef logic [7:0] duty_t;

    // command codes
    typedef enum logic [7:0] {
        CMD_OFF       = 8'd0,
        CMD_ALL       = 8'd1,
        CMD_SET_ZONE  = 8'd2,
        CMD_SET_MOTOR = 8'd3,
        CMD_WAVE      = 8'd4,
        CMD_SESSION   = 8'd5
    } cmd_t;

    // register indexes
    typedef enum logic [2:0] {
        REG_OWN_BED_ID       = 3'd0,
        REG_DUTY_FLOOR_SMALL = 3'd1,
        REG_DUTY_FLOOR_BIG   = 3'd2,
        REG_BIG_MOTOR_MASK   = 3'd3,
        REG_ZONE_MAP         = 3'd4,
        REG_KICK_MS          = 3'd5,
        REG_WAVE_STEP_MS     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  own_bed_id;
        logic [7:0]  duty_floor_small;
        logic [7:0]  duty_floor_big;
        logic [7:0]  big_motor_mask;
        logic [15:0] zone_map;
        logic [7:0]  kick_ms;
        logic [15:0] wave_step_ms;
    } cfg_t;

    typedef struct packed {
        level_t     level;
        logic [7:0] kick;
    } motor_t;

    typedef struct packed {
        logic wave_running;
        logic session_armed;
        logic message_taken;
    } status_t;

    // apply a new level to one motor, handling the start kick
    function automatic motor_t set_motor(motor_t cur, logic [7:0] lvl_in,
                                         logic [7:0] mn, logic [7:0] kick_ms);
        level_t lv;
        logic   d_zero;
        logic   d_full;
        motor_t res;
        lv     = (lvl_in > 8'(LEVEL_MAX)) ? 7'(LEVEL_MAX) : lvl_in[6:0];
        d_zero = (lv == 7'd0) || ((mn == 8'd0) && (lv == 7'd1));
        d_full = (lv == 7'(LEVEL_MAX)) || (mn == 8'(DUTY_FULL));
        res.level = lv;
        res.kick  = cur.kick;
        if (d_zero)
        begin
            res.kick = 8'd0;
        end
        else if ((cur.level == 7'd0) && !d_full)
        begin
            res.kick = kick_ms;
        end
        return res;
    endfunction

endpackage

### hdl/multi_motor_pwm_command_controller.sv
// ----------------------------------------------------------------------------
// multi_motor_pwm_command_controller: eight-motor PWM command controller
// Takes command messages and millisecond ticks and returns the duty of
// every motor plus wave, timer and message status after each item.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           contents
//  s_*       in         s_tvalid/s_tready   command message or tick
//  m_*       out        m_tvalid/m_tready   eight duties and status flags
//  apb       in/out     psel/penable        seven configuration registers
//
//  one item accepted per cycle while the result register is free; three
//  register stages (state update, span product, divide by 99 through a
//  reciprocal multiply) carry its result into the output register in turn
//  the three stages advance together whenever the result register is empty
//  or being taken; a stall on m_tready holds the whole pipeline
//  reset clears valid flags and control state at once; no clearing pass
//
module multi_motor_pwm_command_controller
(
    input  logic        clk,
    input  logic        rst_n,

    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // bed_id, command, target, value
    input  logic        s_tuser,   // req_type

    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // duty_motor0..duty_motor7, wave_running,
                                   // session_armed, message_taken, zero fill

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mmpc_pkg::cfg_t                                cfg;
    mmpc_pkg::motor_t [mmpc_pkg::MOTOR_COUNT-1:0]  motors;
    mmpc_pkg::status_t                             status;
    mmpc_pkg::status_t                             out_status;
    mmpc_pkg::duty_t  [mmpc_pkg::DUTY_LANES-1:0]   duty;
    logic                                          item_valid;
    logic                                          out_valid;
    logic                                          advance;
    logic                                          accept;

    // pipeline moves when the result register is free
    assign advance  = !out_valid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    mmpc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mmpc_state_update u_state
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .advance    (advance),
        .accept     (accept),
        .req_type   (s_tuser),
        .bed_id     (s_tdata[7:0]),
        .command    (s_tdata[15:8]),
        .target     (s_tdata[23:16]),
        .value      (s_tdata[31:24]),
        .motors     (motors),
        .status     (status),
        .item_valid (item_valid)
    );

    mmpc_duty_map u_duty
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cfg        (cfg),
        .item_valid (item_valid),
        .motors     (motors),
        .status     (status),
        .out_valid  (out_valid),
        .duty       (duty),
        .out_status (out_status)
    );

    // result transfer
    assign m_tvalid = out_valid;
    assign m_tdata  = {5'd0,
                       out_status.message_taken,
                       out_status.session_armed,
                       out_status.wave_running,
                       duty};

endmodule

### hdl/mmpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mmpc_cfg_regs: configuration register file
// APB-style write and read access to the seven controller registers.
// ----------------------------------------------------------------------------
module mmpc_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mmpc_pkg::cfg_t      cfg
);

    mmpc_pkg::cfg_t     cfg_reg;
    mmpc_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = mmpc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_bed_id       <= mmpc_pkg::RST_OWN_BED_ID;
            cfg_reg.duty_floor_small <= mmpc_pkg::RST_DUTY_FLOOR_SMALL;
            cfg_reg.duty_floor_big   <= mmpc_pkg::RST_DUTY_FLOOR_BIG;
            cfg_reg.big_motor_mask   <= mmpc_pkg::RST_BIG_MOTOR_MASK;
            cfg_reg.zone_map         <= mmpc_pkg::RST_ZONE_MAP;
            cfg_reg.kick_ms          <= mmpc_pkg::RST_KICK_MS;
            cfg_reg.wave_step_ms     <= mmpc_pkg::RST_WAVE_STEP_MS;
        end
        else if (wr_en)
        begin
            unique case (idx)
                mmpc_pkg::REG_OWN_BED_ID:       cfg_reg.own_bed_id       <= pwdata[7:0];
                mmpc_pkg::REG_DUTY_FLOOR_SMALL: cfg_reg.duty_floor_small <= pwdata[7:0];
                mmpc_pkg::REG_DUTY_FLOOR_BIG:   cfg_reg.duty_floor_big   <= pwdata[7:0];
                mmpc_pkg::REG_BIG_MOTOR_MASK:   cfg_reg.big_motor_mask   <= pwdata[7:0];
                mmpc_pkg::REG_ZONE_MAP:         cfg_reg.zone_map         <= pwdata[15:0];
                mmpc_pkg::REG_KICK_MS:          cfg_reg.kick_ms          <= pwdata[7:0];
                mmpc_pkg::REG_WAVE_STEP_MS:     cfg_reg.wave_step_ms     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            mmpc_pkg::REG_OWN_BED_ID:       prdata = {24'd0, cfg_reg.own_bed_id};
            mmpc_pkg::REG_DUTY_FLOOR_SMALL: prdata = {24'd0, cfg_reg.duty_floor_small};
            mmpc_pkg::REG_DUTY_FLOOR_BIG:   prdata = {24'd0, cfg_reg.duty_floor_big};
            mmpc_pkg::REG_BIG_MOTOR_MASK:   prdata = {24'd0, cfg_reg.big_motor_mask};
            mmpc_pkg::REG_ZONE_MAP:         prdata = {16'd0, cfg_reg.zone_map};
            mmpc_pkg::REG_KICK_MS:          prdata = {24'd0, cfg_reg.kick_ms};
            mmpc_pkg::REG_WAVE_STEP_MS:     prdata = {16'd0, cfg_reg.wave_step_ms};
            default:                        prdata = 32'd0;
        endcase
    end

endmodule

### hdl/mmpc_state_update.sv
// ----------------------------------------------------------------------------
// mmpc_state_update: command and tick state update
// Decodes one item per cycle while the pipeline advances and updates motor levels,
// kick counters, the wave preset and the session timer in a single registered pass.
// ----------------------------------------------------------------------------
module mmpc_state_update
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  mmpc_pkg::cfg_t                                cfg,
    input  logic                                          advance,
    input  logic                                          accept,
    input  logic                                          req_type,
    input  logic [7:0]                                    bed_id,
    input  logic [7:0]                                    command,
    input  logic [7:0]                                    target,
    input  logic [7:0]                                    value,
    output mmpc_pkg::motor_t [mmpc_pkg::MOTOR_COUNT-1:0]  motors,
    output mmpc_pkg::status_t                             status,
    output logic                                          item_valid
);

    mmpc_pkg::motor_t [mmpc_pkg::MOTOR_COUNT-1:0] motor_reg;
    mmpc_pkg::motor_t [mmpc_pkg::MOTOR_COUNT-1:0] motor_next;
    logic                          wave_active_reg, wave_active_next;
    logic [mmpc_pkg::PHASE_W-1:0]  wave_phase_reg, wave_phase_next;
    logic [7:0]                    wave_level_reg, wave_level_next;
    logic [15:0]                   wave_countdown_reg, wave_countdown_next;
    logic                          timer_active_reg, timer_active_next;
    logic [23:0]                   timer_remaining_reg, timer_remaining_next;
    logic                          taken_reg, taken_next;
    logic                          item_valid_reg;

    logic [7:0] mn     [mmpc_pkg::MOTOR_COUNT];
    logic [1:0] zone   [mmpc_pkg::MOTOR_COUNT];

    // per motor minimum duty and zone
    always_comb
    begin
        for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++)
        begin
            mn[m]   = cfg.big_motor_mask[m] ? cfg.duty_floor_big : cfg.duty_floor_small;
            zone[m] = cfg.zone_map[2*m +: 2];
        end
    end

    // next state for one item
    always_comb
    begin
        motor_next           = motor_reg;
        wave_active_next     = wave_active_reg;
        wave_phase_next      = wave_phase_reg;
        wave_level_next      = wave_level_reg;
        wave_countdown_next  = wave_countdown_reg;
        timer_active_next    = timer_active_reg;
        timer_remaining_next = timer_remaining_reg;
        taken_next           = 1'b0;

        if (accept && !req_type)
        begin
            // command message
            if ((bed_id == cfg.own_bed_id) || (bed_id == 8'd0))
            begin
                taken_next = 1'b1;
                case (mmpc_pkg::cmd_t'(command))
                    mmpc_pkg::CMD_OFF:
                    begin
                        wave_active_next     = 1'b0;
                        timer_active_next    = 1'b0;
                        timer_remaining_next = 24'd0;
                        for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++)
                        begin
                            motor_next[m] = mmpc_pkg::set_motor(motor_next[m], 8'd0,
                                                                mn[m], cfg.kick_ms);
                        end
                    end
                    mmpc_pkg::CMD_ALL:
                    begin
                        wave_active_next = 1'b0;
                        for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++)
                        begin
                            motor_next[m] = mmpc_pkg::set_motor(motor_next[m], value,
                                                                mn[m], cfg.kick_ms);
                        end
                    end
                    mmpc_pkg::CMD_SET_ZONE:
                    begin
                        wave_active_next = 1'b0;
                        for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++)
                        begin
                            if ({6'd0, zone[m]} == target)
                            begin
                                motor_next[m] = mmpc_pkg::set_motor(motor_next[m], value,
                                                                    mn[m], cfg.kick_ms);
                            end
                        end
                    end
                    mmpc_pkg::CMD_SET_MOTOR:
                    begin
                        wave_active_next = 1'b0;
                        for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++)
                        begin
                            if (target == 8'(m))
                            begin
                                motor_next[m] = mmpc_pkg::set_motor(motor_next[m], value,
                                                                    mn[m], cfg.kick_ms);
                            end
                        end
                    end
                    mmpc_pkg::CMD_WAVE:
                    begin
                        if (target == 8'd0)
                        begin
                            wave_active_next    = 1'b1;
                            wave_phase_next     = '0;
                            wave_level_next     = (value != 8'd0) ? value
                                                  : 8'(mmpc_pkg::WAVE_LEVEL_DEFAULT);
                            wave_countdown_next = 16'd0;
                        end
                    end
                    mmpc_pkg::CMD_SESSION:
                    begin
                        timer_active_next    = 1'b1;
                        timer_remaining_next = 24'(value) * 24'(mmpc_pkg::MS_PER_MIN);
                    end
                    default: ;
                endcase
            end
        end
        else if (accept)
        begin
            // millisecond tick: kick counters run down first
            for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++)
            begin
                if (motor_next[m].kick != 8'd0)
                begin
                    motor_next[m].kick = motor_next[m].kick - 8'd1;
                end
            end

            // session timer
            if (timer_active_reg)
            begin
                if (timer_remaining_reg == 24'd0)
                begin
                    timer_active_next = 1'b0;
                    wave_active_next  = 1'b0;
                    for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++)
                    begin
                        motor_next[m] = mmpc_pkg::set_motor(motor_next[m], 8'd0,
                                                            mn[m], cfg.kick_ms);
                    end
                end
                else
                begin
                    timer_remaining_next = timer_remaining_reg - 24'd1;
                end
            end

            // wave preset step
            if (wave_active_next)
            begin
                if (wave_countdown_reg == 16'd0)
                begin
                    for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++)
                    begin
                        if ({1'b0, zone[m]} < 3'(mmpc_pkg::ZONE_COUNT))
                        begin
                            motor_next[m] = mmpc_pkg::set_motor(
                                motor_next[m],
                                (zone[m] == wave_phase_reg) ? wave_level_reg
                                                            : {2'd0, wave_level_reg[7:2]},
                                mn[m], cfg.kick_ms);
                        end
                    end
                    if ({1'b0, wave_phase_reg} == 3'(mmpc_pkg::ZONE_COUNT - 1))
                    begin
                        wave_phase_next = '0;
                    end
                    else
                    begin
                        wave_phase_next = wave_phase_reg + 2'd1;
                    end
                    wave_countdown_next = (cfg.wave_step_ms != 16'd0)
                                          ? cfg.wave_step_ms - 16'd1 : 16'd0;
                end
                else
                begin
                    wave_countdown_next = wave_countdown_reg - 16'd1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_reg           <= '0;
            wave_active_reg     <= 1'b0;
            wave_phase_reg      <= '0;
            wave_level_reg      <= 8'(mmpc_pkg::WAVE_LEVEL_DEFAULT);
            wave_countdown_reg  <= 16'd0;
            timer_active_reg    <= 1'b0;
            timer_remaining_reg <= 24'd0;
            taken_reg           <= 1'b0;
            item_valid_reg      <= 1'b0;
        end
        else
        begin
            motor_reg           <= motor_next;
            wave_active_reg     <= wave_active_next;
            wave_phase_reg      <= wave_phase_next;
            wave_level_reg      <= wave_level_next;
            wave_countdown_reg  <= wave_countdown_next;
            timer_active_reg    <= timer_active_next;
            timer_remaining_reg <= timer_remaining_next;
            if (advance)
            begin
                taken_reg      <= taken_next;
                item_valid_reg <= accept;
            end
        end
    end

    assign motors               = motor_reg;
    assign status.wave_running  = wave_active_reg;
    assign status.session_armed = timer_active_reg;
    assign status.message_taken = taken_reg;
    assign item_valid           = item_valid_reg;

endmodule

### hdl/mmpc_duty_map.sv
// ----------------------------------------------------------------------------
// mmpc_duty_map: level to duty mapping and result register
// Two registered stages: span product, then divide by 99 through a
// reciprocal multiply, kick override and the result register.
// ----------------------------------------------------------------------------
module mmpc_duty_map
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          advance,
    input  mmpc_pkg::cfg_t                                cfg,
    input  logic                                          item_valid,
    input  mmpc_pkg::motor_t [mmpc_pkg::MOTOR_COUNT-1:0]  motors,
    input  mmpc_pkg::status_t                             status,
    output logic                                          out_valid,
    output mmpc_pkg::duty_t [mmpc_pkg::DUTY_LANES-1:0]    duty,
    output mmpc_pkg::status_t                             out_status
);

    logic              s2_valid_reg;
    mmpc_pkg::status_t s2_status_reg;
    logic              out_valid_reg;
    mmpc_pkg::status_t out_status_reg;

    // pipeline valid and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= item_valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_status_reg  <= status;
            out_status_reg <= s2_status_reg;
        end
    end

    // one mapper per motor lane
    for (genvar g = 0; g < mmpc_pkg::DUTY_LANES; g++)
    begin : g_lane
        if (g < mmpc_pkg::MOTOR_COUNT)
        begin : g_motor
            logic [7:0]  mn;
            logic [7:0]  span;
            logic [6:0]  step;
            logic [14:0] prod;
            logic [14:0] prod_reg;
            logic [7:0]  base_reg;
            logic        kick_on_reg;
            logic        off_reg;
            logic [29:0] scaled;
            logic [8:0]  sum;
            logic [7:0]  duty_reg;
            logic [7:0]  duty_next;

            // stage 2: (255 - min) * (level - 1)
            assign mn   = cfg.big_motor_mask[g] ? cfg.duty_floor_big : cfg.duty_floor_small;
            assign span = 8'(mmpc_pkg::DUTY_FULL) - mn;
            assign step = motors[g].level - 7'd1;
            assign prod = {7'd0, span} * {8'd0, step};

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    prod_reg    <= prod;
                    base_reg    <= mn;
                    kick_on_reg <= (motors[g].kick != 8'd0);
                    off_reg     <= (motors[g].level == 7'd0);
                end
            end

            // stage 3: divide by 99 and add the minimum
            assign scaled = {15'd0, prod_reg} * 30'(mmpc_pkg::RECIP_99);
            assign sum    = {1'b0, base_reg}
                            + {1'b0, scaled[mmpc_pkg::RECIP_SHIFT +: 8]};

            always_comb
            begin
                if (kick_on_reg)
                begin
                    duty_next = 8'(mmpc_pkg::DUTY_FULL);
                end
                else if (off_reg)
                begin
                    duty_next = 8'd0;
                end
                else
                begin
                    duty_next = sum[7:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    duty_reg <= duty_next;
                end
            end

            assign duty[g] = duty_reg;
        end
        else
        begin : g_unused
            assign duty[g] = 8'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;

endmodule
